FILE: rtl/a32d_pkg.sv
package a32d_pkg;

    // fixed field widths
    localparam int REG_W        = 27;
    localparam int WORD_W       = 32;
    localparam int HEADER_BYTES = 4;
    localparam int CKSUM_BYTES  = 4;
    localparam int ADLER_MOD    = 65521;

    // reset values of the length bounds
    localparam logic [REG_W-1:0] MIN_LEN_RESET = REG_W'(10);
    localparam logic [REG_W-1:0] MAX_LEN_RESET = REG_W'(67108864);

    // register indexes
    localparam logic CFG_MIN_LEN = 1'b0;
    localparam logic CFG_MAX_LEN = 1'b1;

    // result kinds
    localparam logic KIND_BODY    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // body byte regions
    localparam logic REGION_NAME    = 1'b0;
    localparam logic REGION_PAYLOAD = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEN  = 2'd1,
        ST_BAD_CK   = 2'd2,
        ST_BAD_NAME = 2'd3
    } status_t;

    typedef struct packed {
        logic             kind;
        logic             region;
        logic [7:0]       data;
        logic             term;
        status_t          status;
        logic [REG_W-1:0] flen;
    } result_t;

endpackage

FILE: rtl/adler32_checked_frame_deframer_core.sv
// a result is registered in the output entry before it appears on m_axis
// throughput: one byte per cycle while s_axis_tready is high, set by parser and checksum
// s_axis_tready drops only while the spare output entry is full (sink stalled two deep)
// reset: synchronous, active low; clears parser state, output entries and sets the
// length bounds to their reset values
module adler32_checked_frame_deframer_core #(
    parameter int LENGTH_BITS = 27
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input transfer
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [7:0] byte_in
    // result transfer
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [39:0]                m_axis_tdata,   // [7:0] data_byte, [9:8] status,
                                                       // [36:10] frame_length, rest zero
    output logic [1:0]                 m_axis_tuser,   // [0] result_kind, [1] region
    output logic                       m_axis_tlast,   // name_terminator
    // configuration writes
    input  logic                       cfg_wr_en,
    input  logic                       cfg_addr,
    input  logic [a32d_pkg::REG_W-1:0] cfg_wr_data
);
    import a32d_pkg::*;

    logic    in_accept;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    // frame parser and checksum
    a32d_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .in_byte     (s_axis_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .res_valid   (res_valid),
        .res         (res)
    );

    // output register with skid entry
    a32d_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_res  (res),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_res   (out_res),
        .out_ready (m_axis_tready)
    );

    // pack result fields
    assign m_axis_tdata = {3'b000, out_res.flen, out_res.status, out_res.data};
    assign m_axis_tuser = {out_res.region, out_res.kind};
    assign m_axis_tlast = out_res.term;

endmodule

FILE: rtl/a32d_parser.sv
module a32d_parser #(
    parameter int LENGTH_BITS = 27
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_accept,
    input  logic [7:0]               in_byte,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_addr,
    input  logic [a32d_pkg::REG_W-1:0] cfg_wr_data,
    output logic                     res_valid,
    output a32d_pkg::result_t        res
);
    import a32d_pkg::*;

    // counters never exceed the frame length, which fits both bounds
    localparam int CNT_W = (LENGTH_BITS < REG_W) ? LENGTH_BITS : REG_W;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_ERROR
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [WORD_W-1:0]   field_shift_reg, field_shift_next;
    logic [CNT_W-1:0]    body_length_reg, body_length_next;
    logic [WORD_W-1:0]   name_length_reg, name_length_next;
    logic [CNT_W-1:0]    byte_count_reg, byte_count_next;
    logic [15:0]         adler_low_reg, adler_low_next;
    logic [15:0]         adler_high_reg, adler_high_next;
    logic [REG_W-1:0]    min_len_reg, max_len_reg;

    logic [WORD_W-1:0]   shifted_word;
    logic [CNT_W-1:0]    cnt_inc;
    logic [CNT_W-1:0]    ck_start;
    logic [CNT_W-1:0]    pos;
    logic                len_bad;
    logic                in_name;
    logic [16:0]         low_sum;
    logic [15:0]         low_mod;
    logic [16:0]         high_sum;
    logic [15:0]         high_mod;
    logic [WORD_W-1:0]   name_limit;
    status_t             verdict;

    // shared datapath terms
    always_comb begin
        shifted_word = {field_shift_reg[WORD_W-9:0], in_byte};
        cnt_inc      = byte_count_reg + CNT_W'(1);
        ck_start     = body_length_reg - CNT_W'(CKSUM_BYTES);
        pos          = byte_count_reg - CNT_W'(4);
        len_bad      = shifted_word[WORD_W-1]
                       || (shifted_word < WORD_W'(min_len_reg))
                       || (shifted_word > WORD_W'(max_len_reg))
                       || (shifted_word < WORD_W'(2 * HEADER_BYTES))
                       || ((shifted_word >> LENGTH_BITS) != '0);
        in_name      = WORD_W'(pos) < name_length_reg;
        // running adler-32, two modular adds
        low_sum      = {1'b0, adler_low_reg} + {9'b0, in_byte};
        low_mod      = (low_sum >= 17'(ADLER_MOD)) ? 16'(low_sum - 17'(ADLER_MOD))
                                                   : low_sum[15:0];
        high_sum     = {1'b0, adler_high_reg} + {1'b0, low_mod};
        high_mod     = (high_sum >= 17'(ADLER_MOD)) ? 16'(high_sum - 17'(ADLER_MOD))
                                                    : high_sum[15:0];
        name_limit   = WORD_W'(body_length_reg) - WORD_W'(2 * HEADER_BYTES);
        // checksum mismatch wins over a bad name length
        if ({adler_high_reg, adler_low_reg} != shifted_word) begin
            verdict = ST_BAD_CK;
        end else if (name_length_reg[WORD_W-1] || (name_length_reg < WORD_W'(2))
                     || (name_length_reg > name_limit)) begin
            verdict = ST_BAD_NAME;
        end else begin
            verdict = ST_OK;
        end
    end

    // frame sequencing
    always_comb begin
        phase_next       = phase_reg;
        field_shift_next = field_shift_reg;
        body_length_next = body_length_reg;
        name_length_next = name_length_reg;
        byte_count_next  = byte_count_reg;
        adler_low_next   = adler_low_reg;
        adler_high_next  = adler_high_reg;
        res_valid        = 1'b0;
        res              = '0;
        if (in_accept) begin
            case (phase_reg)
                PH_HEADER: begin
                    if (byte_count_reg == CNT_W'(HEADER_BYTES - 1)) begin
                        if (len_bad) begin
                            res_valid  = 1'b1;
                            res.kind   = KIND_VERDICT;
                            res.status = ST_BAD_LEN;
                            res.flen   = shifted_word[REG_W-1:0];
                            phase_next = PH_ERROR;
                        end else begin
                            body_length_next = shifted_word[CNT_W-1:0];
                            field_shift_next = '0;
                            byte_count_next  = '0;
                            phase_next       = PH_BODY;
                        end
                    end else begin
                        field_shift_next = shifted_word;
                        byte_count_next  = cnt_inc;
                    end
                end
                PH_BODY: begin
                    byte_count_next = cnt_inc;
                    if (byte_count_reg < ck_start) begin
                        adler_low_next  = low_mod;
                        adler_high_next = high_mod;
                        if (byte_count_reg < CNT_W'(4)) begin
                            name_length_next = {name_length_reg[WORD_W-9:0], in_byte};
                        end else begin
                            res_valid  = 1'b1;
                            res.kind   = KIND_BODY;
                            res.region = in_name ? REGION_NAME : REGION_PAYLOAD;
                            res.data   = in_byte;
                            res.term   = in_name
                                         && ((WORD_W'(pos) + WORD_W'(1)) == name_length_reg);
                        end
                    end else begin
                        field_shift_next = shifted_word;
                        if (cnt_inc == body_length_reg) begin
                            res_valid  = 1'b1;
                            res.kind   = KIND_VERDICT;
                            res.status = verdict;
                            res.flen   = REG_W'(body_length_reg);
                            if (verdict != ST_OK) begin
                                phase_next = PH_ERROR;
                            end else begin
                                phase_next       = PH_HEADER;
                                field_shift_next = '0;
                                body_length_next = '0;
                                name_length_next = '0;
                                byte_count_next  = '0;
                                adler_low_next   = 16'd1;
                                adler_high_next  = '0;
                            end
                        end
                    end
                end
                default: begin
                    // error lockout: bytes are dropped until reset
                end
            endcase
        end
    end

    // state and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HEADER;
            field_shift_reg <= '0;
            body_length_reg <= '0;
            name_length_reg <= '0;
            byte_count_reg  <= '0;
            adler_low_reg   <= 16'd1;
            adler_high_reg  <= '0;
            min_len_reg     <= MIN_LEN_RESET;
            max_len_reg     <= MAX_LEN_RESET;
        end else begin
            phase_reg       <= phase_next;
            field_shift_reg <= field_shift_next;
            body_length_reg <= body_length_next;
            name_length_reg <= name_length_next;
            byte_count_reg  <= byte_count_next;
            adler_low_reg   <= adler_low_next;
            adler_high_reg  <= adler_high_next;
            if (cfg_wr_en && (cfg_addr == CFG_MIN_LEN)) begin
                min_len_reg <= cfg_wr_data;
            end
            if (cfg_wr_en && (cfg_addr == CFG_MAX_LEN)) begin
                max_len_reg <= cfg_wr_data;
            end
        end
    end

endmodule

FILE: rtl/a32d_skid.sv
module a32d_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  a32d_pkg::result_t push_res,
    output logic              in_ready,
    output logic              out_valid,
    output a32d_pkg::result_t out_res,
    input  logic              out_ready
);
    import a32d_pkg::*;

    logic    main_valid_reg, skid_valid_reg;
    result_t main_reg, skid_reg;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    // output register plus one spare entry for a stalled sink
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (push && main_valid_reg && !pop) begin
            skid_valid_reg <= 1'b1;
        end else if (push) begin
            main_valid_reg <= 1'b1;
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_reg <= skid_reg;
            end
        end else if (push && main_valid_reg && !pop) begin
            skid_reg <= push_res;
        end else if (push) begin
            main_reg <= push_res;
        end
    end

endmodule
